// ===== src/arl_pkg.sv =====
// Shared types and constants for the array list engine.
// Depends on nothing; imported by array_list_engine and by tb.
package arl_pkg;

  localparam int unsigned CapacityDef = 128;

  localparam logic signed [7:0] NotFound = -8'sd1;

  typedef enum logic [2:0] {
    KindInsert  = 3'd0,
    KindDelete  = 3'd1,
    KindFind    = 3'd2,
    KindGet     = 3'd3,
    KindReplace = 3'd4,
    KindClear   = 3'd5
  } kind_e;

  typedef enum logic [5:0] {
    StIdle     = 6'b000001,
    StShiftUp  = 6'b000010,
    StWriteVal = 6'b000100,
    StShiftDn  = 6'b001000,
    StFind     = 6'b010000,
    StGet      = 6'b100000
  } state_e;

endpackage

// ===== src/array_list_engine.sv =====
// Array list engine: ordered list of 32-bit words in a one-port-read, one-port-write store.
// Depends on arl_pkg for request kinds, state codes and the default capacity.
// Replace, clear and rejected requests finish without entering a work state; get finishes from StGet;
// find scans entries in StFind until a match or the end of the list; insert and delete move one entry
// per cycle through the store's single read and single write port (StShiftUp then StWriteVal, or StShiftDn).
// One item is worked on at a time; the next is taken when the result register is free.
// Reset clears the entry count and the handshake state; the store itself is not cleared.
module array_list_engine #(
  parameter int unsigned Capacity = arl_pkg::CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic signed [7:0]  found_index_o,
  output logic signed [31:0] read_value_o,
  output logic [7:0]         count_o
);
  import arl_pkg::*;

  localparam int unsigned LenW = $clog2(Capacity + 1);
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CmpW = ((LenW > 8) ? LenW : 8) + 1;

  state_e            state_q, state_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   pos_q;
  logic [31:0]       val_q;
  logic              out_valid_q;
  logic              status_q;
  logic signed [7:0] found_q;
  logic [31:0]       rdval_q;
  logic [7:0]        count_q;

  logic [31:0]       mem [Capacity];
  logic [31:0]       rdata_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata;

  logic              accept, fin, fin_status;
  logic signed [7:0] fin_found;
  logic [31:0]       fin_rd;

  logic [CmpW-1:0] pos_w, len_w, idx_w, pos_qw, cap_w;
  logic [CmpW-1:0] pos_inc_w, len_inc_w, len_dec_w;
  logic [CmpW-1:0] idx_inc_w, idx_inc2_w, idx_dec_w, idx_dec2_w;

  assign pos_w      = CmpW'(position_i);
  assign len_w      = CmpW'(len_q);
  assign idx_w      = CmpW'(idx_q);
  assign pos_qw     = CmpW'(pos_q);
  assign cap_w      = CmpW'(Capacity);
  assign pos_inc_w  = pos_w + 1'b1;
  assign len_inc_w  = len_w + 1'b1;
  assign len_dec_w  = len_w - 1'b1;
  assign idx_inc_w  = idx_w + 1'b1;
  assign idx_inc2_w = idx_w + 2'd2;
  assign idx_dec_w  = idx_w - 1'b1;
  assign idx_dec2_w = idx_w - 2'd2;

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    idx_d      = idx_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = idx_q;
    mem_raddr  = idx_q;
    mem_wdata  = rdata_q;
    fin        = 1'b0;
    fin_status = 1'b0;
    fin_found  = NotFound;
    fin_rd     = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (kind_i)
            KindInsert: begin
              if (len_w < cap_w && pos_w <= len_w) begin
                if (pos_w == len_w) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_w[IdxW-1:0];
                  mem_wdata = $unsigned(value_i);
                  len_d     = len_inc_w[LenW-1:0];
                  fin       = 1'b1;
                end else begin
                  // Move entries up from the top end, one per cycle.
                  mem_re    = 1'b1;
                  mem_raddr = len_dec_w[IdxW-1:0];
                  idx_d     = len_w[IdxW-1:0];
                  state_d   = StShiftUp;
                end
              end else begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end
            end
            KindDelete: begin
              if (pos_w < len_w) begin
                if (pos_inc_w < len_w) begin
                  mem_re    = 1'b1;
                  mem_raddr = pos_inc_w[IdxW-1:0];
                  idx_d     = pos_w[IdxW-1:0];
                  state_d   = StShiftDn;
                end else begin
                  len_d = len_dec_w[LenW-1:0];
                  fin   = 1'b1;
                end
              end else begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end
            end
            KindFind: begin
              if (len_w != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_d     = '0;
                state_d   = StFind;
              end else begin
                fin = 1'b1;
              end
            end
            KindGet: begin
              if (pos_w < len_w) begin
                mem_re    = 1'b1;
                mem_raddr = pos_w[IdxW-1:0];
                state_d   = StGet;
              end else begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end
            end
            KindReplace: begin
              if (pos_w < len_w) begin
                mem_we    = 1'b1;
                mem_waddr = pos_w[IdxW-1:0];
                mem_wdata = $unsigned(value_i);
              end else begin
                fin_status = 1'b1;
              end
              fin = 1'b1;
            end
            KindClear: begin
              len_d = '0;
              fin   = 1'b1;
            end
            default: begin
              fin        = 1'b1;
              fin_status = 1'b1;
            end
          endcase
        end
      end
      StShiftUp: begin
        // The read of the next lower entry never hits the entry written now.
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rdata_q;
        if (idx_dec_w > pos_qw) begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec2_w[IdxW-1:0];
          idx_d     = idx_dec_w[IdxW-1:0];
        end else begin
          state_d = StWriteVal;
        end
      end
      StWriteVal: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
        len_d     = len_inc_w[LenW-1:0];
        fin       = 1'b1;
        state_d   = StIdle;
      end
      StShiftDn: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rdata_q;
        if (idx_inc2_w < len_w) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc2_w[IdxW-1:0];
          idx_d     = idx_inc_w[IdxW-1:0];
        end else begin
          len_d   = len_dec_w[LenW-1:0];
          fin     = 1'b1;
          state_d = StIdle;
        end
      end
      StFind: begin
        if (rdata_q == val_q) begin
          fin_found = idx_w[7:0];
          fin       = 1'b1;
          state_d   = StIdle;
        end else if (idx_inc_w < len_w) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc_w[IdxW-1:0];
          idx_d     = idx_inc_w[IdxW-1:0];
        end else begin
          fin     = 1'b1;
          state_d = StIdle;
        end
      end
      StGet: begin
        fin_rd  = rdata_q;
        fin     = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (accept) begin
      pos_q <= pos_w[IdxW-1:0];
      val_q <= $unsigned(value_i);
    end
    if (fin) begin
      status_q <= fin_status;
      found_q  <= fin_found;
      rdval_q  <= fin_rd;
      count_q  <= 8'(CmpW'(len_d));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign read_value_o  = $signed(rdval_q);
  assign count_o       = count_q;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for array_list_engine: requests go through a bursty driver,
// and results are compared against an in-bench list predictor by a stalling monitor.
// Depends on arl_pkg for the request kinds, the not-found code and the default capacity.
`timescale 1ns / 1ps

module tb;
  import arl_pkg::*;

  localparam int unsigned Cap = CapacityDef;
  localparam int unsigned SlotW = $clog2(Cap);
  localparam int unsigned RandomItems = 900;
  localparam int unsigned DrainCycles = 300;

  // Kind codes the block does not define; they must be rejected.
  localparam logic [2:0] KindSpare6 = 3'd6;
  localparam logic [2:0] KindSpare7 = 3'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         pos;
    logic signed [31:0] val;
  } list_req_t;

  typedef struct packed {
    logic               status;
    logic signed [7:0]  found;
    logic signed [31:0] rd;
    logic [7:0]         count;
  } list_rsp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         kind_i = KindClear;
  logic [7:0]         position_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               status_o;
  logic signed [7:0]  found_index_o;
  logic signed [31:0] read_value_o;
  logic [7:0]         count_o;

  always #5 clk_i = ~clk_i;

  array_list_engine #(
    .Capacity(Cap)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

  // Predicted list contents and run statistics.
  logic signed [31:0] list_entries [Cap];
  int                 list_len = 0;
  int                 rejected_cnt = 0;
  int                 find_hits = 0;
  int                 peak_len = 0;
  int                 full_cnt = 0;
  int                 errors = 0;
  int                 accepted_cnt = 0;
  int                 checked_cnt = 0;

  list_req_t pending_reqs[$];
  list_rsp_t expected_rsps[$];

  // Stimulus-side view of the count, used only to aim positions inside the list and to fill it to capacity.
  int         gen_len = 0;
  int         queued_cnt = 0;
  logic [31:0] value_pool [8];

  function automatic list_rsp_t predict_list_op(list_req_t r);
    list_rsp_t o;
    int        i;
    bit        hit;
    o.status = 1'b0;
    o.found  = NotFound;
    o.rd     = '0;
    hit      = 1'b0;
    case (r.kind)
      KindInsert: begin
        if (list_len < Cap && int'(r.pos) <= list_len) begin
          for (i = list_len; i > int'(r.pos); i--) begin
            list_entries[SlotW'(i)] = list_entries[SlotW'(i-1)];
          end
          list_entries[SlotW'(r.pos)] = r.val;
          list_len++;
          if (list_len == Cap) full_cnt++;
        end else begin
          o.status = 1'b1;
        end
      end
      KindDelete: begin
        if (int'(r.pos) < list_len) begin
          for (i = int'(r.pos) + 1; i < list_len; i++) begin
            list_entries[SlotW'(i-1)] = list_entries[SlotW'(i)];
          end
          list_len--;
        end else begin
          o.status = 1'b1;
        end
      end
      KindFind: begin
        for (i = 0; i < list_len && !hit; i++) begin
          if (list_entries[SlotW'(i)] == r.val) begin
            o.found = i[7:0];
            hit     = 1'b1;
          end
        end
        if (hit) find_hits++;
      end
      KindGet: begin
        if (int'(r.pos) < list_len) o.rd = list_entries[SlotW'(r.pos)];
        else o.status = 1'b1;
      end
      KindReplace: begin
        if (int'(r.pos) < list_len) list_entries[SlotW'(r.pos)] = r.val;
        else o.status = 1'b1;
      end
      KindClear: list_len = 0;
      default: o.status = 1'b1;
    endcase
    if (o.status) rejected_cnt++;
    if (list_len > peak_len) peak_len = list_len;
    o.count = list_len[7:0];
    return o;
  endfunction

  task automatic queue_req(logic [2:0] kind, int pos, logic [31:0] val);
    list_req_t r;
    r.kind = kind;
    r.pos  = pos[7:0];
    r.val  = val;
    pending_reqs.push_back(r);
    queued_cnt++;
    case (kind)
      KindInsert: if (gen_len < Cap && pos <= gen_len) gen_len++;
      KindDelete: if (pos < gen_len) gen_len--;
      KindClear:  gen_len = 0;
      default: ;
    endcase
  endtask

  // Half of the values come from a small pool so that finds hit and duplicates occur.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return value_pool[3'($urandom_range(0, 7))];
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic int pick_slot();
    if ($urandom_range(0, 9) == 0 || gen_len == 0) return $urandom_range(0, 255);
    return $urandom_range(0, gen_len - 1);
  endfunction

  task automatic fill_to_capacity();
    while (gen_len < Cap) queue_req(KindInsert, $urandom_range(0, gen_len), pick_value());
    queue_req(KindInsert, Cap, pick_value());
    queue_req(KindInsert, 0, pick_value());
    queue_req(KindGet, Cap - 1, $urandom);
    queue_req(KindReplace, Cap - 1, pick_value());
    queue_req(KindFind, 0, pick_value());
    queue_req(KindFind, 0, $urandom);
    queue_req(KindDelete, Cap - 1, $urandom);
    queue_req(KindDelete, 0, $urandom);
    queue_req(KindInsert, 0, pick_value());
    queue_req(KindGet, Cap, $urandom);
    queue_req(KindClear, $urandom_range(0, 255), $urandom);
  endtask

  // Driver: sends pending items in bursts with random gaps and predicts each accepted one.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    list_req_t nxt;
    list_req_t sent;
    int        r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        sent.kind = kind_i;
        sent.pos  = position_i;
        sent.val  = value_i;
        expected_rsps.push_back(predict_list_op(sent));
        accepted_cnt++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          kind_i     <= nxt.kind;
          position_i <= nxt.pos;
          value_i    <= nxt.val;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            r = $urandom_range(0, 9);
            gap_left = (r < 4) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(5, 20);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: checks each accepted result and stalls in patterns that change over time.
  int stall_mode = 0;
  int mode_left = 0;
  int phase_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    list_rsp_t exp_r;
    logic      nxt_stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        checked_cnt++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: result with no request outstanding: status %0d count %0d",
                   $time, status_o, count_o);
          errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          report_field("status", longint'(exp_r.status), longint'(status_o));
          report_field("found_index", longint'(exp_r.found), longint'(found_index_o));
          report_field("read_value", longint'(exp_r.rd), longint'(read_value_o));
          report_field("count", longint'(exp_r.count), longint'(count_o));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      phase_cnt++;
      case (stall_mode)
        0: nxt_stall = 1'b0;
        1: nxt_stall = ($urandom_range(0, 99) < 35);
        default: nxt_stall = ((phase_cnt % 7) < 3);
      endcase
      out_stall_i <= nxt_stall;
    end
  end

  initial begin : stimulus
    int        i;
    int        r;
    int        target;
    bit        filled_a;
    bit        filled_b;
    logic [2:0] k;
    filled_a = 1'b0;
    filled_b = 1'b0;
    for (i = 0; i < 8; i++) value_pool[3'(i)] = $urandom;

    // Directed part: empty-list rejects, edges of position and value, spare kinds.
    queue_req(KindClear, 0, 32'h0);
    queue_req(KindDelete, 0, 32'h0);
    queue_req(KindGet, 0, 32'h0);
    queue_req(KindReplace, 0, 32'h1);
    queue_req(KindFind, 0, 32'h0);
    queue_req(KindInsert, 1, 32'h1234_5678);
    queue_req(KindInsert, 0, 32'h8000_0000);
    queue_req(KindInsert, 1, 32'h7fff_ffff);
    queue_req(KindInsert, 1, 32'h0000_0000);
    queue_req(KindInsert, 0, 32'hffff_ffff);
    queue_req(KindFind, 0, 32'h7fff_ffff);
    queue_req(KindFind, 0, 32'h0000_3039);
    queue_req(KindGet, 3, 32'h0);
    queue_req(KindGet, 4, 32'h0);
    queue_req(KindGet, 255, 32'hffff_ffff);
    queue_req(KindReplace, 0, 32'h5555_5555);
    queue_req(KindReplace, 4, 32'haaaa_aaaa);
    queue_req(KindDelete, 4, 32'h0);
    queue_req(KindDelete, 0, 32'h0);
    queue_req(KindDelete, 2, 32'h0);
    queue_req(KindSpare6, 128, 32'hffff_ffff);
    queue_req(KindSpare7, 255, 32'h0);
    queue_req(KindInsert, 128, 32'h1);
    queue_req(KindInsert, 2, 32'h0);
    queue_req(KindFind, 0, 32'h0);
    queue_req(KindClear, 0, 32'h0);

    target = queued_cnt + RandomItems;
    while (queued_cnt < target) begin
      if (!filled_a && queued_cnt > target - 650) begin
        fill_to_capacity();
        filled_a = 1'b1;
      end else if (!filled_b && queued_cnt > target - 250) begin
        fill_to_capacity();
        filled_b = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) value_pool[3'($urandom_range(0, 7))] = $urandom;
      r = $urandom_range(0, 99);
      if (r < 30) begin
        queue_req(KindInsert, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, gen_len),
                  pick_value());
      end else if (r < 45) begin
        queue_req(KindDelete, pick_slot(), $urandom);
      end else if (r < 65) begin
        queue_req(KindFind, $urandom_range(0, 255), pick_value());
      end else if (r < 80) begin
        queue_req(KindGet, pick_slot(), $urandom);
      end else if (r < 90) begin
        queue_req(KindReplace, pick_slot(), pick_value());
      end else if (r < 93) begin
        queue_req(KindClear, $urandom_range(0, 255), $urandom);
      end else if (r < 95) begin
        k = $urandom_range(0, 1) ? KindSpare7 : KindSpare6;
        queue_req(k, $urandom_range(0, 255), $urandom);
      end else begin
        k = 3'($urandom_range(0, 7));
        queue_req(k, $urandom_range(0, 255), $urandom);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < queued_cnt) @(negedge clk_i);
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Ran %0d list requests and checked %0d results; %0d were rejected, %0d finds hit.",
             accepted_cnt, checked_cnt, rejected_cnt, find_hits);
    $display("The list peaked at %0d entries and reached capacity %0d times.",
             peak_len, full_cnt);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("%0t: timed out with %0d of %0d items accepted", $time, accepted_cnt, queued_cnt);
    $display("FAILURE");
    $finish;
  end

endmodule
